FILE: rtl/dsc_pkg.sv
// Constants for the date serial to civil date and time-of-day converter.
package dsc_pkg;

	localparam int DAY_BITS = 24;
	localparam int FRAC_BITS = 32;

	localparam int SEC_BITS = 17;
	localparam int SEC_SUM_BITS = FRAC_BITS + 10;
	localparam logic [SEC_BITS-1:0] SECS_PER_DAY = SEC_BITS'(86400);
	localparam logic [9:0] SEC_SCALE = 10'd675;

	localparam int Z_BITS = ((DAY_BITS - 1 > 20) ? DAY_BITS - 1 : 20) + 1;
	localparam int ERA_BITS = Z_BITS - 17;
	localparam int Y_BITS = ERA_BITS + 10;
	localparam logic [Z_BITS-1:0] EPOCH_OFFSET = Z_BITS'(719468 - 25569);

	localparam int DOE_BITS = 18;
	localparam int YOE_BITS = 9;
	localparam int DOY_BITS = 9;
	localparam int MP_BITS = 4;
	localparam int REM_BITS = 12;

	localparam int DAYS_PER_ERA = 146097;
	localparam int DAYS_LAST_ERA = 146096;
	localparam int YEARS_PER_ERA = 400;
	localparam int SECS_PER_HOUR = 3600;
	localparam int SECS_PER_MIN = 60;
	localparam logic [MP_BITS-1:0] MP_JANUARY = MP_BITS'(10);

	// Exact reciprocals: q = (x * ceil(2^k / d)) >> k, with k = bits(x) + bits(d).
	localparam int ERA_SHIFT = Z_BITS + 18;
	localparam int ERA_RCP_BITS = ERA_SHIFT - 17;
	localparam int ERA_PROD_BITS = Z_BITS + ERA_RCP_BITS;
	localparam logic [ERA_RCP_BITS-1:0] ERA_RCP =
		ERA_RCP_BITS'(((64'd1 << ERA_SHIFT) + 64'd146096) / 64'd146097);

	localparam int SH_1460 = 29;
	localparam logic [18:0] RCP_1460 = 19'(((64'd1 << SH_1460) + 64'd1459) / 64'd1460);
	localparam int SH_36524 = 34;
	localparam logic [18:0] RCP_36524 = 19'(((64'd1 << SH_36524) + 64'd36523) / 64'd36524);
	localparam int SH_365 = 27;
	localparam logic [18:0] RCP_365 = 19'(((64'd1 << SH_365) + 64'd364) / 64'd365);
	localparam int SH_100 = 16;
	localparam logic [9:0] RCP_100 = 10'(((64'd1 << SH_100) + 64'd99) / 64'd100);
	localparam int SH_153 = 19;
	localparam logic [11:0] RCP_153 = 12'(((64'd1 << SH_153) + 64'd152) / 64'd153);
	localparam int SH_5 = 14;
	localparam logic [11:0] RCP_5 = 12'(((64'd1 << SH_5) + 64'd4) / 64'd5);
	localparam int SH_3600 = 29;
	localparam logic [17:0] RCP_3600 = 18'(((64'd1 << SH_3600) + 64'd3599) / 64'd3600);
	localparam int SH_60 = 18;
	localparam logic [12:0] RCP_60 = 13'(((64'd1 << SH_60) + 64'd59) / 64'd60);

endpackage

FILE: rtl/date_serial_to_civil_unit.sv
// Pipelined converter from a fixed-point date serial to civil date and time of day.
//
// Channel  Direction  Handshake            Payload
// in       input      in_valid, in_stall   serial_days, serial_fraction
// out      output     out_valid, out_stall valid_res, year, month, day, hour,
//                                          minute, second, has_time
//
// Ten register stages, s1 to s10, between acceptance and output.
// One transaction can enter every cycle while out_stall is low; the throughput is set
// by the single shared stall chain, and each stage refills as soon as its content moves on.
// Reset clears only the valid bits of the stages.
// A stalled output holds its transaction while empty upstream stages still fill.
module date_serial_to_civil_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [dsc_pkg::DAY_BITS-1:0] serial_days,
	input  logic [dsc_pkg::FRAC_BITS-1:0]       serial_fraction,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                valid_res,
	output logic [14:0]                         year,
	output logic [3:0]                          month,
	output logic [4:0]                          day,
	output logic [4:0]                          hour,
	output logic [5:0]                          minute,
	output logic [5:0]                          second,
	output logic                                has_time
);
	import dsc_pkg::*;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9, vld_s10;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7, en_s8, en_s9, en_s10;

	logic                  neg_s1, neg_s2, neg_s3, neg_s4, neg_s5, neg_s6, neg_s7, neg_s8;
	logic                  neg_s9;
	logic [DAY_BITS-2:0]   days_s1;
	logic [SEC_BITS-1:0]   secs_s1, secs_s2, secs_s3;
	logic [Z_BITS-1:0]     z_s2, z_s3;
	logic [ERA_BITS-1:0]   era_s3, era_s4, era_s5, era_s6;
	logic [4:0]            hh_s3, hh_s4, hh_s5, hh_s6, hh_s7, hh_s8, hh_s9;
	logic [5:0]            mm_s5, mm_s6, mm_s7, mm_s8, mm_s9;
	logic [5:0]            ss_s6, ss_s7, ss_s8, ss_s9;
	logic [REM_BITS-1:0]   rem_s4, rem_s5;
	logic [DOE_BITS-1:0]   doe_s4, doe_s5, doe_s6;
	logic [6:0]            c1460_s5;
	logic [2:0]            c36524_s5;
	logic                  c146096_s5;
	logic [YOE_BITS-1:0]   yoe_s6;
	logic [DOY_BITS-1:0]   doy_s7, doy_s8, doy_s9;
	logic [Y_BITS-1:0]     ybase_s7, ybase_s8, year_s9;
	logic [MP_BITS-1:0]    mp_s8, month_s9;
	logic [10:0]           w_s9;

	logic                  valid_res_s10, has_time_s10;
	logic [14:0]           year_s10;
	logic [3:0]            month_s10;
	logic [4:0]            day_s10, hour_s10;
	logic [5:0]            minute_s10, second_s10;

	logic [SEC_SUM_BITS-1:0]  sec_sum;
	logic                     sec_wrap;
	logic [ERA_PROD_BITS-1:0] era_prod;
	logic [34:0]              hh_prod;
	logic [Z_BITS-1:0]        era_base, doe_full;
	logic [SEC_BITS-1:0]      hh_base, rem_full;
	logic [36:0]              p1460, p36524, pyoe;
	logic [24:0]              pmm;
	logic [DOE_BITS-1:0]      t_days;
	logic [REM_BITS-1:0]      mm_base, ss_full;
	logic [18:0]              pcent;
	logic [DOE_BITS-1:0]      yoe_days, doy_full;
	logic [10:0]              mp_num;
	logic [22:0]              pmp, pday;
	logic                     late_year;
	logic [DOY_BITS-1:0]      day_full;

	assign en_s10 = !vld_s10 || !out_stall;
	assign en_s9  = !vld_s9 || en_s10;
	assign en_s8  = !vld_s8 || en_s9;
	assign en_s7  = !vld_s7 || en_s8;
	assign en_s6  = !vld_s6 || en_s7;
	assign en_s5  = !vld_s5 || en_s6;
	assign en_s4  = !vld_s4 || en_s5;
	assign en_s3  = !vld_s3 || en_s4;
	assign en_s2  = !vld_s2 || en_s3;
	assign en_s1  = !vld_s1 || en_s2;
	assign in_stall = !en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
		end else begin
			if (en_s1)  vld_s1  <= in_valid;
			if (en_s2)  vld_s2  <= vld_s1;
			if (en_s3)  vld_s3  <= vld_s2;
			if (en_s4)  vld_s4  <= vld_s3;
			if (en_s5)  vld_s5  <= vld_s4;
			if (en_s6)  vld_s6  <= vld_s5;
			if (en_s7)  vld_s7  <= vld_s6;
			if (en_s8)  vld_s8  <= vld_s7;
			if (en_s9)  vld_s9  <= vld_s8;
			if (en_s10) vld_s10 <= vld_s9;
		end
	end

	always_comb begin
		sec_sum = SEC_SUM_BITS'(serial_fraction) * SEC_SUM_BITS'(SEC_SCALE)
			+ (SEC_SUM_BITS'(1) << (FRAC_BITS - 8));

		sec_wrap = secs_s1 >= SECS_PER_DAY;

		era_prod = ERA_PROD_BITS'(z_s2) * ERA_PROD_BITS'(ERA_RCP);
		hh_prod  = 35'(secs_s2) * 35'(RCP_3600);

		era_base = Z_BITS'(era_s3) * Z_BITS'(DAYS_PER_ERA);
		doe_full = z_s3 - era_base;
		hh_base  = SEC_BITS'(hh_s3) * SEC_BITS'(SECS_PER_HOUR);
		rem_full = secs_s3 - hh_base;

		p1460  = 37'(doe_s4) * 37'(RCP_1460);
		p36524 = 37'(doe_s4) * 37'(RCP_36524);
		pmm    = 25'(rem_s4) * 25'(RCP_60);

		t_days  = doe_s5 - DOE_BITS'(c1460_s5) + DOE_BITS'(c36524_s5)
			- DOE_BITS'(c146096_s5);
		pyoe    = 37'(t_days) * 37'(RCP_365);
		mm_base = REM_BITS'(mm_s5) * REM_BITS'(SECS_PER_MIN);
		ss_full = rem_s5 - mm_base;

		pcent    = 19'(yoe_s6) * 19'(RCP_100);
		yoe_days = DOE_BITS'(yoe_s6) * DOE_BITS'(365) + DOE_BITS'(yoe_s6[YOE_BITS-1:2])
			- DOE_BITS'(pcent[SH_100 +: 2]);
		doy_full = doe_s6 - yoe_days;

		mp_num = 11'(doy_s7) * 11'(5) + 11'(2);
		pmp    = 23'(mp_num) * 23'(RCP_153);

		late_year = mp_s8 >= MP_JANUARY;

		pday     = 23'(w_s9) * 23'(RCP_5);
		day_full = doy_s9 - pday[SH_5 +: DOY_BITS] + DOY_BITS'(1);
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			neg_s1  <= serial_days[DAY_BITS-1];
			days_s1 <= serial_days[DAY_BITS-2:0];
			secs_s1 <= sec_sum[FRAC_BITS-7 +: SEC_BITS];
		end
		if (en_s2) begin
			neg_s2  <= neg_s1;
			secs_s2 <= sec_wrap ? secs_s1 - SECS_PER_DAY : secs_s1;
			z_s2    <= Z_BITS'(days_s1) + Z_BITS'(sec_wrap) + EPOCH_OFFSET;
		end
		if (en_s3) begin
			neg_s3  <= neg_s2;
			z_s3    <= z_s2;
			secs_s3 <= secs_s2;
			era_s3  <= era_prod[ERA_SHIFT +: ERA_BITS];
			hh_s3   <= hh_prod[SH_3600 +: 5];
		end
		if (en_s4) begin
			neg_s4 <= neg_s3;
			era_s4 <= era_s3;
			hh_s4  <= hh_s3;
			doe_s4 <= doe_full[DOE_BITS-1:0];
			rem_s4 <= rem_full[REM_BITS-1:0];
		end
		if (en_s5) begin
			neg_s5     <= neg_s4;
			era_s5     <= era_s4;
			hh_s5      <= hh_s4;
			doe_s5     <= doe_s4;
			rem_s5     <= rem_s4;
			c1460_s5   <= p1460[SH_1460 +: 7];
			c36524_s5  <= p36524[SH_36524 +: 3];
			c146096_s5 <= doe_s4 == DOE_BITS'(DAYS_LAST_ERA);
			mm_s5      <= pmm[SH_60 +: 6];
		end
		if (en_s6) begin
			neg_s6 <= neg_s5;
			era_s6 <= era_s5;
			hh_s6  <= hh_s5;
			mm_s6  <= mm_s5;
			doe_s6 <= doe_s5;
			yoe_s6 <= pyoe[SH_365 +: YOE_BITS];
			ss_s6  <= ss_full[5:0];
		end
		if (en_s7) begin
			neg_s7   <= neg_s6;
			hh_s7    <= hh_s6;
			mm_s7    <= mm_s6;
			ss_s7    <= ss_s6;
			doy_s7   <= doy_full[DOY_BITS-1:0];
			ybase_s7 <= Y_BITS'(yoe_s6) + Y_BITS'(era_s6) * Y_BITS'(YEARS_PER_ERA);
		end
		if (en_s8) begin
			neg_s8   <= neg_s7;
			hh_s8    <= hh_s7;
			mm_s8    <= mm_s7;
			ss_s8    <= ss_s7;
			doy_s8   <= doy_s7;
			ybase_s8 <= ybase_s7;
			mp_s8    <= pmp[SH_153 +: MP_BITS];
		end
		if (en_s9) begin
			neg_s9   <= neg_s8;
			hh_s9    <= hh_s8;
			mm_s9    <= mm_s8;
			ss_s9    <= ss_s8;
			doy_s9   <= doy_s8;
			w_s9     <= 11'(mp_s8) * 11'(153) + 11'(2);
			month_s9 <= late_year ? mp_s8 - MP_BITS'(9) : mp_s8 + MP_BITS'(3);
			year_s9  <= ybase_s8 + Y_BITS'(late_year);
		end
		if (en_s10) begin
			valid_res_s10 <= !neg_s9;
			year_s10      <= neg_s9 ? '0 : 15'(year_s9);
			month_s10     <= neg_s9 ? '0 : month_s9;
			day_s10       <= neg_s9 ? '0 : day_full[4:0];
			hour_s10      <= neg_s9 ? '0 : hh_s9;
			minute_s10    <= neg_s9 ? '0 : mm_s9;
			second_s10    <= neg_s9 ? '0 : ss_s9;
			has_time_s10  <= !neg_s9 && ((hh_s9 != '0) || (mm_s9 != '0) || (ss_s9 != '0));
		end
	end

	assign out_valid = vld_s10;
	assign valid_res = valid_res_s10;
	assign year      = year_s10;
	assign month     = month_s10;
	assign day       = day_s10;
	assign hour      = hour_s10;
	assign minute    = minute_s10;
	assign second    = second_s10;
	assign has_time  = has_time_s10;

endmodule

FILE: dv/date_serial_to_civil_unit_tb.sv
`timescale 1ns / 1ps
// Testbench for the date serial to civil date and time-of-day converter.
module date_serial_to_civil_unit_tb;
	import dsc_pkg::*;

	localparam int LONG_HOLD_AT = 140;
	localparam int LONG_HOLD_CYCLES = 100;
	localparam int RANDOM_SERIALS = 500;

	typedef struct packed {
		logic        valid_res;
		logic [14:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic        has_time;
	} civil_t;

	typedef struct {
		logic signed [DAY_BITS-1:0] days;
		logic [FRAC_BITS-1:0]       frac;
		int                         gap;
		bit                         drain;
	} serial_item_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        in_valid = 1'b0;
	logic                        in_stall;
	logic signed [DAY_BITS-1:0]  serial_days = '0;
	logic [FRAC_BITS-1:0]        serial_fraction = '0;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	logic                        valid_res;
	logic [14:0]                 year;
	logic [3:0]                  month;
	logic [4:0]                  day;
	logic [4:0]                  hour;
	logic [5:0]                  minute;
	logic [5:0]                  second;
	logic                        has_time;

	serial_item_t pending_serials[$];
	civil_t       expected_dates[$];
	serial_item_t next_serial;
	civil_t       want_date;
	int           send_wait = 0;
	int           recv_wait = 0;
	int           dates_seen = 0;
	int           mismatches = 0;
	logic         next_valid;

	date_serial_to_civil_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.serial_days(serial_days),
		.serial_fraction(serial_fraction),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.valid_res(valid_res),
		.year(year),
		.month(month),
		.day(day),
		.hour(hour),
		.minute(minute),
		.second(second),
		.has_time(has_time)
	);

	always #2 clk = ~clk;

	function automatic civil_t civil_from_serial(input logic signed [DAY_BITS-1:0] sd,
			input logic [FRAC_BITS-1:0] sf);
		civil_t r;
		longint unsigned d, secs, z, era, doe, yoe, doy, mp, y, m, dd, hh, mm, ss;
		r = '0;
		if (sd < 0)
			return r;
		d = longint'(sd);
		secs = (longint'(sf) * 64'd675 + (64'd1 << (FRAC_BITS - 8))) >> (FRAC_BITS - 7);
		if (secs >= 64'd86400) begin
			secs -= 64'd86400;
			d += 64'd1;
		end
		z = d + 64'd719468 - 64'd25569;
		era = z / 64'd146097;
		doe = z - era * 64'd146097;
		yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
		y = yoe + era * 400;
		doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
		mp = (5 * doy + 2) / 153;
		dd = doy - (153 * mp + 2) / 5 + 1;
		m = (mp < 10) ? mp + 3 : mp - 9;
		if (m <= 2)
			y += 1;
		hh = secs / 3600;
		mm = (secs % 3600) / 60;
		ss = secs % 60;
		r.valid_res = 1'b1;
		r.year = y[14:0];
		r.month = m[3:0];
		r.day = dd[4:0];
		r.hour = hh[4:0];
		r.minute = mm[5:0];
		r.second = ss[5:0];
		r.has_time = (hh != 0 || mm != 0 || ss != 0);
		return r;
	endfunction

	task automatic add_serial(input logic signed [DAY_BITS-1:0] sd,
			input logic [FRAC_BITS-1:0] sf, input int gap, input bit drain);
		serial_item_t it;
		it.days = sd;
		it.frac = sf;
		it.gap = gap;
		it.drain = drain;
		pending_serials.push_back(it);
	endtask

	task automatic compare_field(input string name, input longint unsigned want,
			input longint unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// Sender: each transaction after the first is preceded by its own idle gap.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			serial_days <= '0;
			serial_fraction <= '0;
			send_wait = 0;
		end else begin
			next_valid = in_valid;
			if (in_valid && !in_stall) begin
				expected_dates.push_back(civil_from_serial(serial_days, serial_fraction));
				next_valid = 1'b0;
				if (pending_serials.size() != 0)
					send_wait = pending_serials[0].gap;
			end
			if (!next_valid) begin
				if (send_wait != 0)
					send_wait--;
				else if (pending_serials.size() != 0 &&
						!(pending_serials[0].drain && expected_dates.size() != 0)) begin
					next_serial = pending_serials.pop_front();
					serial_days <= next_serial.days;
					serial_fraction <= next_serial.frac;
					next_valid = 1'b1;
				end
			end
			in_valid <= next_valid;
		end
	end

	// Receiver: checks each transaction and draws the stall before the next one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			recv_wait = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_dates.size() == 0) begin
					$error("result arrived with no transaction outstanding");
					mismatches++;
				end else begin
					want_date = expected_dates.pop_front();
					compare_field("valid_res", want_date.valid_res, valid_res);
					compare_field("year", want_date.year, year);
					compare_field("month", want_date.month, month);
					compare_field("day", want_date.day, day);
					compare_field("hour", want_date.hour, hour);
					compare_field("minute", want_date.minute, minute);
					compare_field("second", want_date.second, second);
					compare_field("has_time", want_date.has_time, has_time);
				end
				dates_seen++;
				if (dates_seen == LONG_HOLD_AT)
					recv_wait = LONG_HOLD_CYCLES;
				else if (dates_seen >= 350 && dates_seen < 420)
					recv_wait = 0;
				else
					recv_wait = $urandom_range(0, 13);
			end else if (recv_wait != 0) begin
				recv_wait--;
			end
			out_stall <= (recv_wait != 0);
		end
	end

	initial begin
		int pick;
		int gap;
		logic signed [DAY_BITS-1:0] sd;
		logic [FRAC_BITS-1:0] sf;

		// Calendar corners, rounding into the next day, exact half second, negatives.
		add_serial(0, 0, $urandom_range(0, 13), 1'b0);
		add_serial(2, 0, $urandom_range(0, 13), 1'b0);
		add_serial(60, 0, $urandom_range(0, 13), 1'b0);
		add_serial(61, 0, $urandom_range(0, 13), 1'b0);
		add_serial(36585, 32'h8000_0000, $urandom_range(0, 13), 1'b0);
		add_serial(36525, 32'd4294942441, $urandom_range(0, 13), 1'b0);
		add_serial(100, 32'd4294942440, $urandom_range(0, 13), 1'b0);
		add_serial(0, 32'hFFFF_FFFF, $urandom_range(0, 13), 1'b0);
		add_serial(24'sh7F_FFFF, 32'hFFFF_FFFF, 0, 1'b0);
		add_serial(24'sh7F_FFFF, 0, 0, 1'b0);
		add_serial(100, 32'h0100_0000, 0, 1'b0);
		add_serial(100, 32'h00FF_FFFF, $urandom_range(0, 13), 1'b0);
		add_serial(100, 1, $urandom_range(0, 13), 1'b0);
		add_serial(-1, 32'hFFFF_FFFF, $urandom_range(0, 13), 1'b0);
		add_serial(24'sh80_0000, 0, $urandom_range(0, 13), 1'b0);
		add_serial(24'sh80_0000, 32'h1234_5678, 0, 1'b0);
		add_serial(24'sh55_5555, 32'hAAAA_AAAA, 0, 1'b0);
		add_serial(24'sh2A_AAAA, 32'h5555_5555, $urandom_range(0, 13), 1'b0);
		add_serial(73050, 32'h7FFF_FFFF, $urandom_range(0, 13), 1'b0);

		for (int i = 0; i < RANDOM_SERIALS; i++) begin
			pick = $urandom_range(0, 9);
			if (pick == 0)
				sd = DAY_BITS'($urandom) | 24'sh80_0000;
			else if (pick <= 3)
				sd = DAY_BITS'($urandom_range(0, 73050));
			else if (pick == 4)
				sd = DAY_BITS'(24'sh7F_FFFF - $urandom_range(0, 1000));
			else
				sd = DAY_BITS'($urandom_range(0, 24'h7F_FFFF));
			pick = $urandom_range(0, 7);
			if (pick == 0)
				sf = 0;
			else if (pick == 1)
				sf = 32'hFFFF_FFFF - $urandom_range(0, 50000);
			else
				sf = $urandom;
			if ((i >= 100 && i < 250) || (i >= 400 && i < 460))
				gap = 0;
			else
				gap = $urandom_range(0, 13);
			add_serial(sd, sf, gap, i == 0 || i == 300);
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_serials.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_dates.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);

		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#2000000;
		$display("tb: failure");
		$finish;
	end

endmodule

FILE: date_serial_to_civil_unit.f
rtl/dsc_pkg.sv
rtl/date_serial_to_civil_unit.sv
dv/date_serial_to_civil_unit_tb.sv
